>>> rtl/core/distance_vector_route_update_top_assert.svh
`ifndef DISTANCE_VECTOR_ROUTE_UPDATE_TOP_ASSERT_SVH
`define DISTANCE_VECTOR_ROUTE_UPDATE_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define DVRU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dvru port check failed");

// next-cycle implication, sampled on clk, off while rst is high
`define DVRU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dvru port check failed");

`endif

>>> rtl/core/dvru_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dvru_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int NUM_IFACES  = 4;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int ADDR_W      = 32;
  localparam int COST_W      = 8;
  localparam int SLOT_W      = 6;
  localparam int COUNT_W     = 7;
  localparam int IFC_CNT_W   = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [COST_W-1:0] COST_MAX = '1;

  // result action codes
  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_UPDATE = 2'd1;
  localparam logic [1:0] ACT_SAME   = 2'd2;
  localparam logic [1:0] ACT_DROP   = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IFACE_ADDR_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IFACE_ADDR_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IFACE_ADDR_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IFACE_ADDR_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IFACE_COUNT  = 3'd4;

  typedef struct packed {
    logic              cmd;
    logic              first_of_message;
    logic [ADDR_W-1:0] dest_addr;
    logic [COST_W-1:0] route_cost;
    logic [ADDR_W-1:0] adv_next_hop;
    logic [ADDR_W-1:0] sender_addr;
    logic [ADDR_W-1:0] recv_iface;
  } in_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] entry_count;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic run;
    logic append;
    logic update;
    logic keep;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic search;
    logic hit;
    logic own;
    logic last;
    logic found;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/distance_vector_route_update_top.sv
`timescale 1ns / 1ps
`default_nettype none

// distance-vector route table update, receive side. each transaction on the input
// channel is one entry of a neighbor's advertisement (cmd 0) or a local route to load
// (cmd 1), and yields exactly one result transaction: appended, updated, unchanged or
// dropped (table full), with the slot touched and the entry count afterwards. the
// table holds up to 64 routes; an advertised entry is looked up only among routes
// present when its message began (first_of_message takes that snapshot). a local load
// or an entry whose snapshot is empty goes from acceptance straight to its finishing
// step. a lookup walks the snapshot in order, one route per cycle behind a registered
// read of the single read port of the destination/cost memory, and stops at the first
// cheaper match (replaced, or kept for an own next hop); otherwise it runs to the end
// of the snapshot. the finishing step waits for a free output register, then writes the
// result and frees the input together. the next input transaction is taken as soon as
// the result sits in the output register, even while the consumer stalls it; its own
// result then waits for that register to free. interface registers must be written
// only while idle; the block itself does not enforce it.

module distance_vector_route_update_top (
  input  wire                              clk,
  input  wire                              rst,
  // advertisement / local route channel
  input  wire                              in_valid,
  output logic                             in_stall,
  input  dvru_pkg::in_t                    in_data,
  // result channel
  output logic                             out_valid,
  input  wire                              out_stall,
  output dvru_pkg::out_t                   out_data,
  // interface address registers
  input  wire                              cfg_we,
  input  wire  [dvru_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [dvru_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // sequencing commands and datapath status
  dvru_pkg::ctrl_cmd_t cmd;
  dvru_pkg::dp_stat_t  stat;

  // state machine: idle, table search, then one finishing step per outcome
  dvru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // route table, search pipeline, interface registers and output register
  dvru_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> rtl/core/dvru_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module dvru_datapath (
  input  wire                                  clk,
  input  wire                                  rst,
  input  dvru_pkg::in_t                        in_data,
  input  wire                                  cfg_we,
  input  wire  [dvru_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [dvru_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  dvru_pkg::ctrl_cmd_t                  cmd,
  output dvru_pkg::dp_stat_t                   stat,
  input  wire                                  out_stall,
  output logic                                 out_valid,
  output dvru_pkg::out_t                       out_data
);

  // table memories, no reset: only written entries are ever used
  logic [dvru_pkg::ADDR_W+dvru_pkg::COST_W-1:0] mem_dest_metric [dvru_pkg::TABLE_DEPTH];
  logic [dvru_pkg::ADDR_W-1:0] mem_next_hop [dvru_pkg::TABLE_DEPTH];
  logic [dvru_pkg::ADDR_W-1:0] mem_iface    [dvru_pkg::TABLE_DEPTH];

  dvru_pkg::in_t                    item;
  logic [dvru_pkg::COST_W-1:0]      new_cost;
  logic [dvru_pkg::CNT_W-1:0]       valid_count;
  logic [dvru_pkg::CNT_W-1:0]       search_limit;
  logic [dvru_pkg::CNT_W-1:0]       iss_idx;
  logic [dvru_pkg::CNT_W-1:0]       cmp_idx;
  logic [dvru_pkg::CNT_W-1:0]       hit_idx;
  logic                             cmp_vld;
  logic                             found;
  logic [dvru_pkg::ADDR_W-1:0]      rd_dest;
  logic [dvru_pkg::COST_W-1:0]      rd_metric;
  logic [dvru_pkg::ADDR_W-1:0]      iface_addr [dvru_pkg::NUM_IFACES];
  logic [dvru_pkg::IFC_CNT_W-1:0]   iface_count;

  logic [dvru_pkg::CNT_W-1:0]       lim_in;
  logic                             match;
  logic                             cheaper;
  logic                             own;
  logic                             full;
  logic                             issue_more;
  logic [dvru_pkg::COST_W-1:0]      app_cost;
  logic [dvru_pkg::ADDR_W-1:0]      app_hop;

  assign lim_in     = in_data.first_of_message ? valid_count : search_limit;
  assign match      = (rd_dest == item.dest_addr);
  assign cheaper    = (new_cost < rd_metric);
  assign full       = (valid_count == dvru_pkg::CNT_W'(dvru_pkg::TABLE_DEPTH));
  assign issue_more = (iss_idx < search_limit);
  // local loads keep their own cost and next hop
  assign app_cost   = item.cmd ? item.route_cost : new_cost;
  assign app_hop    = item.cmd ? item.adv_next_hop : item.sender_addr;

  always_comb begin
    own = 1'b0;
    for (int k = 0; k < dvru_pkg::NUM_IFACES; k++) begin
      if ((iface_count > dvru_pkg::IFC_CNT_W'(k)) && (iface_addr[k] == item.adv_next_hop)) begin
        own = 1'b1;
      end
    end
  end

  assign stat.search   = !in_data.cmd && (lim_in != '0);
  assign stat.hit      = cmp_vld && match && cheaper;
  assign stat.own      = own;
  assign stat.last     = cmp_vld &&
                         (dvru_pkg::CNT_W'(cmp_idx + dvru_pkg::CNT_W'(1)) == search_limit);
  assign stat.found    = found || (cmp_vld && match);
  assign stat.out_free = !out_valid || !out_stall;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_count  <= '0;
      search_limit <= '0;
      cmp_vld      <= 1'b0;
      out_valid    <= 1'b0;
      iface_count  <= '0;
      for (int k = 0; k < dvru_pkg::NUM_IFACES; k++) begin
        iface_addr[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          dvru_pkg::REG_IFACE_ADDR_0: iface_addr[0] <= cfg_data;
          dvru_pkg::REG_IFACE_ADDR_1: iface_addr[1] <= cfg_data;
          dvru_pkg::REG_IFACE_ADDR_2: iface_addr[2] <= cfg_data;
          dvru_pkg::REG_IFACE_ADDR_3: iface_addr[3] <= cfg_data;
          dvru_pkg::REG_IFACE_COUNT:  iface_count   <= cfg_data[dvru_pkg::IFC_CNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        search_limit <= lim_in;
        cmp_vld      <= 1'b0;
      end else begin
        cmp_vld <= cmd.run && issue_more;
      end
      // a new result refills the register in the cycle the old one leaves
      if (cmd.append || cmd.update || cmd.keep) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.append && !full) begin
        valid_count <= dvru_pkg::CNT_W'(valid_count + dvru_pkg::CNT_W'(1));
      end
    end
  end

  // item, search pipeline, table and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item     <= in_data;
      new_cost <= (in_data.route_cost == dvru_pkg::COST_MAX) ? dvru_pkg::COST_MAX :
                  dvru_pkg::COST_W'(in_data.route_cost + dvru_pkg::COST_W'(1));
      iss_idx  <= '0;
      found    <= 1'b0;
    end
    if (cmd.run) begin
      {rd_dest, rd_metric} <= mem_dest_metric[iss_idx[dvru_pkg::IDX_W-1:0]];
      cmp_idx <= iss_idx;
      if (issue_more) begin
        iss_idx <= dvru_pkg::CNT_W'(iss_idx + dvru_pkg::CNT_W'(1));
      end
      if (cmp_vld && match) begin
        found <= 1'b1;
      end
      if (stat.hit) begin
        hit_idx <= cmp_idx;
      end
    end
    if (cmd.append) begin
      if (full) begin
        out_data.action      <= dvru_pkg::ACT_DROP;
        out_data.slot        <= '0;
        out_data.entry_count <= dvru_pkg::COUNT_W'(valid_count);
      end else begin
        mem_dest_metric[valid_count[dvru_pkg::IDX_W-1:0]] <= {item.dest_addr, app_cost};
        mem_next_hop[valid_count[dvru_pkg::IDX_W-1:0]]    <= app_hop;
        mem_iface[valid_count[dvru_pkg::IDX_W-1:0]]       <= item.recv_iface;
        out_data.action      <= dvru_pkg::ACT_APPEND;
        out_data.slot        <= dvru_pkg::SLOT_W'(valid_count);
        out_data.entry_count <= dvru_pkg::COUNT_W'(valid_count + dvru_pkg::CNT_W'(1));
      end
    end
    if (cmd.update) begin
      // destination matched, so rewriting it keeps it
      mem_dest_metric[hit_idx[dvru_pkg::IDX_W-1:0]] <= {item.dest_addr, new_cost};
      mem_next_hop[hit_idx[dvru_pkg::IDX_W-1:0]]    <= item.sender_addr;
      mem_iface[hit_idx[dvru_pkg::IDX_W-1:0]]       <= item.recv_iface;
      out_data.action      <= dvru_pkg::ACT_UPDATE;
      out_data.slot        <= dvru_pkg::SLOT_W'(hit_idx);
      out_data.entry_count <= dvru_pkg::COUNT_W'(valid_count);
    end
    if (cmd.keep) begin
      out_data.action      <= dvru_pkg::ACT_SAME;
      out_data.slot        <= '0;
      out_data.entry_count <= dvru_pkg::COUNT_W'(valid_count);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/dvru_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dvru_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  dvru_pkg::dp_stat_t   stat,
  output dvru_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_APPEND = 5'b00100,
    S_UPDATE = 5'b01000,
    S_KEEP   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = stat.search ? S_SEARCH : S_APPEND;
        end
      end
      S_SEARCH: begin
        cmd.run = 1'b1;
        // first cheaper match decides; otherwise run to the end of the snapshot
        if (stat.hit) begin
          state_next = stat.own ? S_KEEP : S_UPDATE;
        end else if (stat.last) begin
          state_next = stat.found ? S_KEEP : S_APPEND;
        end
      end
      S_APPEND: begin
        if (stat.out_free) begin
          cmd.append = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_UPDATE: begin
        if (stat.out_free) begin
          cmd.update = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_KEEP: begin
        if (stat.out_free) begin
          cmd.keep   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/dvru_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "distance_vector_route_update_top_assert.svh"

module dvru_checker (
  input wire                              clk,
  input wire                              rst,
  input wire                              in_valid,
  input wire                              in_stall,
  input dvru_pkg::in_t                    in_data,
  input wire                              out_valid,
  input wire                              out_stall,
  input dvru_pkg::out_t                   out_data
);

  logic                         no_slot_act;
  logic                         drop_act;
  logic                         append_act;
  logic [dvru_pkg::COUNT_W-1:0] slot_plus_one;

  assign no_slot_act   = out_valid && (out_data.action == dvru_pkg::ACT_SAME ||
                                       out_data.action == dvru_pkg::ACT_DROP);
  assign drop_act      = out_valid && (out_data.action == dvru_pkg::ACT_DROP);
  assign append_act    = out_valid && (out_data.action == dvru_pkg::ACT_APPEND);
  assign slot_plus_one = dvru_pkg::COUNT_W'({1'b0, out_data.slot} + 7'd1);

  // a stalled input transaction holds
  `DVRU_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data))

  // a stalled result holds
  `DVRU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // only appends and updates name a slot
  `DVRU_ASSERT_NOW(a_slot_zero, no_slot_act, out_data.slot == '0)

  // drops happen only with the table full
  `DVRU_ASSERT_NOW(a_drop_full, drop_act, out_data.entry_count == 7'd64)

  // an append lands on the slot numbered by the old count, one below the new count
  `DVRU_ASSERT_NOW(a_append_slot, append_act, out_data.entry_count == slot_plus_one)

endmodule

bind distance_vector_route_update_top dvru_checker u_checker (.*);

`default_nettype wire

>>> tb/route_table_checker.sv
`timescale 1ns / 1ps

module route_table_checker (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  input  wire                              in_stall,
  input  dvru_pkg::in_t                    in_data,
  input  wire                              out_valid,
  input  wire                              out_stall,
  input  dvru_pkg::out_t                   out_data,
  input  wire                              cfg_we,
  input  wire  [dvru_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [dvru_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               fail_count,
  output int                               pending
);
  import dvru_pkg::*;

  // shadow route table
  logic [ADDR_W-1:0]    rt_dest [TABLE_DEPTH];
  logic [COST_W-1:0]    rt_cost [TABLE_DEPTH];
  logic [ADDR_W-1:0]    rt_hop  [TABLE_DEPTH];
  logic [ADDR_W-1:0]    rt_ifc  [TABLE_DEPTH];
  int unsigned          n_routes;
  int unsigned          snap_routes;

  // shadow interface registers
  logic [ADDR_W-1:0]    own_addr [4];
  logic [IFC_CNT_W-1:0] own_count;

  out_t                 expected_outcomes [$];

  function automatic bit hop_is_own(input logic [ADDR_W-1:0] hop);
    int n;
    int k;
    n = (own_count > NUM_IFACES) ? NUM_IFACES : int'(own_count);
    for (k = 0; k < n; k++)
      if (own_addr[k] == hop) return 1'b1;
    return 1'b0;
  endfunction

  task automatic add_route(input logic [ADDR_W-1:0] dest, input logic [COST_W-1:0] cost,
                           input logic [ADDR_W-1:0] hop, input logic [ADDR_W-1:0] ifc,
                           inout out_t res);
    if (n_routes >= TABLE_DEPTH) begin
      res.action = ACT_DROP;
      res.slot   = '0;
    end else begin
      rt_dest[n_routes] = dest;
      rt_cost[n_routes] = cost;
      rt_hop[n_routes]  = hop;
      rt_ifc[n_routes]  = ifc;
      res.action = ACT_APPEND;
      res.slot   = n_routes[SLOT_W-1:0];
      n_routes++;
    end
  endtask

  task automatic route_update(input in_t it, output out_t res);
    logic [COST_W:0]   sum;
    logic [COST_W-1:0] metric;
    int unsigned       lim;
    int unsigned       i;
    bit                found;
    bit                decided;
    res = '0;
    res.action = ACT_SAME;
    if (it.first_of_message) snap_routes = n_routes;
    if (it.cmd) begin
      add_route(it.dest_addr, it.route_cost, it.adv_next_hop, it.recv_iface, res);
    end else begin
      sum    = {1'b0, it.route_cost} + 1'b1;
      metric = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
      lim    = (snap_routes > n_routes) ? n_routes : snap_routes;
      found   = 1'b0;
      decided = 1'b0;
      // first stored match with a higher cost decides, even when refused
      for (i = 0; i < lim && !decided; i++) begin
        if (rt_dest[i] == it.dest_addr) begin
          found = 1'b1;
          if (metric < rt_cost[i]) begin
            decided = 1'b1;
            if (!hop_is_own(it.adv_next_hop)) begin
              rt_hop[i]  = it.sender_addr;
              rt_ifc[i]  = it.recv_iface;
              rt_cost[i] = metric;
              res.action = ACT_UPDATE;
              res.slot   = i[SLOT_W-1:0];
            end
          end
        end
      end
      if (!found) add_route(it.dest_addr, metric, it.sender_addr, it.recv_iface, res);
    end
    res.entry_count = n_routes[COUNT_W-1:0];
  endtask

  task automatic flag(input string what, input out_t want, input out_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t route check, %s: exp action %0d slot %0d count %0d, got %0d %0d %0d",
               $time, what, want.action, want.slot, want.entry_count,
               got.action, got.slot, got.entry_count);
  endtask

  always @(posedge clk) begin : monitor
    out_t predicted;
    out_t want;
    if (rst) begin
      n_routes    = 0;
      snap_routes = 0;
      own_addr[0] = '0;
      own_addr[1] = '0;
      own_addr[2] = '0;
      own_addr[3] = '0;
      own_count   = '0;
      expected_outcomes.delete();
      fail_count  = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IFACE_ADDR_0: own_addr[0] = cfg_data;
          REG_IFACE_ADDR_1: own_addr[1] = cfg_data;
          REG_IFACE_ADDR_2: own_addr[2] = cfg_data;
          REG_IFACE_ADDR_3: own_addr[3] = cfg_data;
          REG_IFACE_COUNT:  own_count   = cfg_data[IFC_CNT_W-1:0];
          default: ;
        endcase
      end
      // compare before predicting so a result never meets its own expectation
      if (out_valid && !out_stall) begin
        if (expected_outcomes.size() == 0) begin
          flag("unexpected result", '0, out_data);
        end else begin
          want = expected_outcomes.pop_front();
          if (out_data.action !== want.action || out_data.slot !== want.slot ||
              out_data.entry_count !== want.entry_count)
            flag("mismatch", want, out_data);
        end
      end
      if (in_valid && !in_stall) begin
        route_update(in_data, predicted);
        expected_outcomes = {expected_outcomes, predicted};
      end
    end
    pending = expected_outcomes.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import dvru_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;  // quiet cycles; longest legal gap is the long hold
  localparam int SETTLE_CYCLES  = 80;    // a full 64-route lookup plus margin
  localparam int PHASE_ITEMS    = 250;
  localparam int LONG_HOLD      = 400;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int fail_count;
  int pending;

  // idle percentages per side, switched between phases
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // long receiver hold, requested by the stimulus, counted by the receiver
  int hold_req  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int quiet_cycles = 0;

  // interface addresses as last written, used to aim next hops at them
  logic [ADDR_W-1:0] own_addr [4];
  // destinations already advertised, so that lookups hit
  logic [ADDR_W-1:0] dest_pool [$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  distance_vector_route_update_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  route_table_checker route_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // result consumer: random stall, or a long hold when one is requested
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog: ends the run when no transaction moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // all register writes happen with the input channel quiet
  task automatic load_ifaces(input logic [ADDR_W-1:0] a0, input logic [ADDR_W-1:0] a1,
                             input logic [ADDR_W-1:0] a2, input logic [ADDR_W-1:0] a3,
                             input logic [IFC_CNT_W-1:0] cnt);
    own_addr[0] = a0;
    own_addr[1] = a1;
    own_addr[2] = a2;
    own_addr[3] = a3;
    cfg_we = 1'b1;
    cfg_index = REG_IFACE_ADDR_0;  cfg_data = a0;  @(negedge clk);
    cfg_index = REG_IFACE_ADDR_1;  cfg_data = a1;  @(negedge clk);
    cfg_index = REG_IFACE_ADDR_2;  cfg_data = a2;  @(negedge clk);
    cfg_index = REG_IFACE_ADDR_3;  cfg_data = a3;  @(negedge clk);
    cfg_index = REG_IFACE_COUNT;   cfg_data = CFG_DATA_W'(cnt);  @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // offer one transaction, starting at a falling edge; valid stays high afterwards
  // so back-to-back transactions never drop it
  task automatic send_route(input in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // wait for every result, then let the block go fully quiet
  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic in_t mk_item(input logic cmd, input logic first,
                                  input logic [ADDR_W-1:0] dest, input logic [COST_W-1:0] cost,
                                  input logic [ADDR_W-1:0] hop, input logic [ADDR_W-1:0] nbr,
                                  input logic [ADDR_W-1:0] ifc);
    in_t it;
    it.cmd              = cmd;
    it.first_of_message = first;
    it.dest_addr        = dest;
    it.route_cost       = cost;
    it.adv_next_hop     = hop;
    it.sender_addr      = nbr;
    it.recv_iface       = ifc;
    return it;
  endfunction

  // random entry: mostly known destinations, some new ones, costs leaning on the edges
  function automatic in_t make_route(input logic first, input logic [ADDR_W-1:0] nbr,
                                     input logic [ADDR_W-1:0] ifc);
    in_t it;
    it.cmd              = ($urandom_range(9) == 0);
    it.first_of_message = first;
    if (dest_pool.size() == 0 || $urandom_range(99) < 8) begin
      it.dest_addr = ($urandom_range(19) == 0) ? '1 : $urandom();
      dest_pool = {dest_pool, it.dest_addr};
    end else begin
      it.dest_addr = dest_pool[$urandom_range(dest_pool.size() - 1)];
    end
    case ($urandom_range(9))
      0:       it.route_cost = '0;
      1:       it.route_cost = 8'd254;
      2:       it.route_cost = '1;
      3:       it.route_cost = 8'd1;
      default: it.route_cost = COST_W'($urandom());
    endcase
    it.adv_next_hop = ($urandom_range(2) == 0) ? own_addr[$urandom_range(3)] : $urandom();
    it.sender_addr  = nbr;
    it.recv_iface   = ifc;
    return it;
  endfunction

  // one advertisement: first entry marked, same neighbor and interface throughout
  task automatic send_message(input int len);
    logic [ADDR_W-1:0] nbr;
    logic [ADDR_W-1:0] ifc;
    int k;
    nbr = $urandom();
    ifc = $urandom_range(1) ? own_addr[$urandom_range(3)] : $urandom();
    for (k = 0; k < len; k++) send_route(make_route(k == 0, nbr, ifc));
  endtask

  // mostly well-formed messages, the rest loose entries with a random start mark
  task automatic run_random(input int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 85) begin
        len = $urandom_range(10, 1);
        send_message(len);
        sent += len;
      end else begin
        send_route(make_route($urandom_range(1), $urandom(), $urandom()));
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    in_t it;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // phase 1: sender idles lightly, receiver heavily; two interfaces in use
    send_idle_pct = 18;
    recv_idle_pct = 55;
    load_ifaces(32'h0A00_0001, 32'hC0A8_0001, 32'h0000_0000, 32'hFFFF_FFFF, 3'd2);

    // local loads at both cost extremes
    send_route(mk_item(1'b1, 1'b1, 32'h0A00_0000, 8'd0, 32'h0, 32'h0, 32'h0A00_0001));
    send_route(mk_item(1'b1, 1'b0, '1, '1, '1, '1, '1));
    // match but not cheaper
    send_route(mk_item(1'b0, 1'b1, 32'h0A00_0000, 8'd0, 32'h0102_0304, $urandom(), $urandom()));
    // cheaper but next hop is an own interface: refused
    send_route(mk_item(1'b0, 1'b0, '1, 8'd2, 32'h0A00_0001, $urandom(), $urandom()));
    // next hop equals an address whose slot is beyond the interface count: accepted
    send_route(mk_item(1'b0, 1'b0, '1, 8'd2, 32'h0, $urandom(), $urandom()));
    // new destination, cost saturates
    send_route(mk_item(1'b0, 1'b0, 32'h0, '1, $urandom(), '1, 32'hC0A8_0001));
    // same destination again within the message: not in the snapshot, appended twice
    send_route(mk_item(1'b0, 1'b0, 32'h0, 8'd10, $urandom(), $urandom(), $urandom()));
    // new message: both copies visible now, neither cheaper
    send_route(mk_item(1'b0, 1'b1, 32'h0, 8'd254, $urandom(), $urandom(), $urandom()));
    // several matches, first one decides and is refused
    send_route(mk_item(1'b0, 1'b0, 32'h0, 8'd5, 32'hC0A8_0001, $urandom(), $urandom()));
    send_route(mk_item(1'b0, 1'b0, 32'h0, 8'd100, $urandom(), $urandom(), $urandom()));
    send_route(mk_item(1'b0, 1'b0, 32'h0, 8'd0, $urandom(), $urandom(), $urandom()));
    // first copy no longer higher, second copy takes the update
    send_route(mk_item(1'b0, 1'b0, 32'h0, 8'd0, $urandom(), 32'h0, 32'h0));
    // start mark on a local load snapshots before the load appends
    send_route(mk_item(1'b1, 1'b1, 32'h0A00_0000, 8'd7, '1, $urandom(), 32'h0));
    send_route(mk_item(1'b0, 1'b0, 32'h0A00_0000, 8'd3, $urandom(), $urandom(), $urandom()));
    send_route(mk_item(1'b0, 1'b1, 32'h0A00_0000, 8'd3, $urandom(), $urandom(), $urandom()));
    send_route(mk_item(1'b0, 1'b1, 32'h1234_5678, '1, '1, 32'h0, 32'h0));
    dest_pool = {dest_pool, 32'h0, 32'hFFFF_FFFF, 32'h0A00_0000};
    run_random(PHASE_ITEMS);
    settle();

    // phase 2: address extremes, count above the number of interfaces
    load_ifaces(32'h0000_0000, 32'hFFFF_FFFF, $urandom(), $urandom(), 3'd7);
    run_random(PHASE_ITEMS);
    settle();

    // phase 3: roles swapped, no own interfaces at all
    send_idle_pct = 55;
    recv_idle_pct = 18;
    load_ifaces($urandom(), $urandom(), $urandom(), $urandom(), 3'd0);
    run_random(PHASE_ITEMS);
    settle();

    // phase 4: a single own interface
    load_ifaces($urandom(), $urandom(), 32'hFFFF_FFFF, 32'h0000_0000, 3'd1);
    run_random(PHASE_ITEMS);
    settle();

    // phase 5: no idling, all four interfaces; the receiver holds off for a long
    // stretch while local loads keep coming, so the block backs up its input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_ifaces($urandom(), $urandom(), $urandom(), $urandom(), 3'd4);
    @(posedge clk);
    hold_req++;
    @(negedge clk);
    // enough fresh loads to leave the table full, then drops and full-depth lookups
    repeat (TABLE_DEPTH) begin
      it = make_route($urandom_range(1), $urandom(), $urandom());
      it.cmd       = 1'b1;
      it.dest_addr = $urandom();
      send_route(it);
    end
    run_random(PHASE_ITEMS - TABLE_DEPTH);
    settle();

    if (fail_count == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/dvru_pkg.sv
rtl/core/dvru_datapath.sv
rtl/core/dvru_ctrl.sv
rtl/core/distance_vector_route_update_top.sv
rtl/core/dvru_checker.sv
tb/route_table_checker.sv
tb/tb.sv
